// ----- rtl/msst_pkg.sv -----
package msst_pkg;

    localparam int SLOTS_DEF = 8;
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int MAX_RESULTS = 8;
    localparam int REP_WIDTH = 16;
    localparam int ID_WIDTH = 8;

    localparam logic [1:0] CMD_SET = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;

    localparam logic [1:0] KIND_FIRE = 2'd0;
    localparam logic [1:0] KIND_END = 2'd1;
    localparam logic [1:0] KIND_NOTFOUND = 2'd2;
    localparam logic [1:0] KIND_FULL = 2'd3;

    localparam logic [REP_WIDTH-1:0] REP_FOREVER = '1;

    typedef struct packed {
        logic                push;
        logic                flush;
        logic [1:0]          kind;
        logic [ID_WIDTH-1:0] id;
    } ev_req_t;

    typedef struct packed {
        logic ready;
        logic pend_valid;
    } ev_stat_t;

endpackage

// ----- rtl/multi_slot_software_timer_top.sv -----
// timer table with SLOTS slots keyed by an 8-bit timer id
// input word: s_tuser carries the command (set, delete, tick), s_tdata the
// timer id, reload period and repeat count; one word is taken at a time
// output word: m_tuser carries the event kind, m_tdata the timer id, m_tlast
// marks the final event caused by an input word; a tick gives up to eight
// events, set and delete at most one
// an accepted word scans the slot memory one slot per cycle through its single
// read port, unless the output side stalls; a tick then flushes its events, and
// a set or delete first writes or frees its slot and posts its event, before s_tready returns
// the first event of a word reaches m_tvalid once a later event or the flush at
// the end of the word pushes it on; events are held one deep plus one output register
// a stalled receiver holds m_tvalid and its word; the scan then waits on the
// slot that has the next event to report, and resumes when m_tready rises
// reset (aresetn low at a clock edge) frees all slots and drops pending events;
// slot contents need no clearing since only slots marked valid are read
module multi_slot_software_timer_top #(
    parameter int SLOTS = msst_pkg::SLOTS_DEF,
    parameter int COUNT_WIDTH = msst_pkg::COUNT_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // timer_id, reload_ticks, repeat_count
    input  logic [1:0]  s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // event_timer_id
    output logic [1:0]  m_tuser,   // event_kind
    output logic        m_tlast    // last_event
);

    import msst_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = COUNT_WIDTH;
    localparam int EW = ID_WIDTH + 2 * CW + REP_WIDTH;
    localparam int EVW = $clog2(MAX_RESULTS + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [IW-1:0]        idx_reg, idx_next;
    logic [EVW-1:0]       evcnt_reg, evcnt_next;
    logic [SLOTS-1:0]     valid_reg, valid_next;
    logic                 found_reg, found_next;
    logic [IW-1:0]        match_reg, match_next;
    logic [1:0]           cmd_reg;
    logic [ID_WIDTH-1:0]  id_reg;
    logic [CW-1:0]        reload_reg;
    logic [REP_WIDTH-1:0] rep_reg;

    logic                 accept;
    logic                 ram_we, ram_re;
    logic [IW-1:0]        ram_waddr, ram_raddr;
    logic [EW-1:0]        ram_wdata, ram_rdata;

    logic [ID_WIDTH-1:0]  e_id;
    logic [CW-1:0]        e_rel, e_cur;
    logic [REP_WIDTH-1:0] e_rep;

    logic                 free_any;
    logic [IW-1:0]        free_idx;
    ev_req_t              ev_req;
    ev_stat_t             ev_stat;

    assign accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign {e_rep, e_cur, e_rel, e_id} = ram_rdata;

    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_any = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    always_comb begin
        logic stall;
        logic ev_want;
        logic [1:0] ev_kind;
        logic [CW-1:0] n_cur;
        logic [REP_WIDTH-1:0] n_rep;

        state_next = state_reg;
        idx_next = idx_reg;
        evcnt_next = evcnt_reg;
        valid_next = valid_reg;
        found_next = found_reg;
        match_next = match_reg;
        ram_we = 1'b0;
        ram_re = 1'b0;
        ram_waddr = idx_reg;
        ram_raddr = IW'(idx_reg + IW'(1));
        ram_wdata = ram_rdata;
        ev_req = '0;
        stall = 1'b0;
        ev_want = 1'b0;
        ev_kind = KIND_FIRE;
        n_cur = e_cur;
        n_rep = e_rep;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    idx_next = '0;
                    evcnt_next = '0;
                    found_next = 1'b0;
                    ram_raddr = '0;
                    if (s_tuser == CMD_SET || s_tuser == CMD_DELETE
                        || s_tuser == CMD_TICK) begin
                        ram_re = 1'b1;
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_SCAN: begin
                if (cmd_reg == CMD_TICK) begin
                    if (valid_reg[idx_reg]) begin
                        if (e_cur != '0) begin
                            n_cur = CW'(e_cur - CW'(1));
                        end else begin
                            n_cur = e_rel;
                            ev_want = 1'b1;
                            if (!e_rep[REP_WIDTH-1] && e_rep != '0) begin
                                n_rep = REP_WIDTH'(e_rep - REP_WIDTH'(1));
                            end else if (e_rep == REP_FOREVER) begin
                                n_rep = e_rep;
                            end else begin
                                ev_kind = KIND_END;
                            end
                        end
                        ev_req.kind = ev_kind;
                        ev_req.id = e_id;
                        ev_req.push = ev_want && (evcnt_reg < EVW'(MAX_RESULTS));
                        stall = ev_req.push && !ev_stat.ready;
                        if (!stall) begin
                            ram_we = 1'b1;
                            ram_wdata = {n_rep, n_cur, e_rel, e_id};
                            if (ev_want && ev_kind == KIND_END) begin
                                valid_next[idx_reg] = 1'b0;
                            end
                            if (ev_req.push) begin
                                evcnt_next = EVW'(evcnt_reg + EVW'(1));
                            end
                        end
                    end
                end else if (valid_reg[idx_reg] && e_id == id_reg) begin
                    found_next = 1'b1;
                    match_next = idx_reg;
                end
                if (!stall) begin
                    if (idx_reg == LAST_IDX) begin
                        state_next = (cmd_reg == CMD_TICK) ? ST_FLUSH : ST_FIN;
                    end else begin
                        idx_next = IW'(idx_reg + IW'(1));
                        ram_re = 1'b1;
                    end
                end
            end
            ST_FIN: begin
                ev_req.id = id_reg;
                if (cmd_reg == CMD_SET) begin
                    ram_waddr = found_reg ? match_reg : free_idx;
                    ram_wdata = {rep_reg, reload_reg, reload_reg, id_reg};
                    if (found_reg || free_any) begin
                        ram_we = 1'b1;
                        valid_next[ram_waddr] = 1'b1;
                    end else begin
                        ev_req.push = 1'b1;
                        ev_req.kind = KIND_FULL;
                    end
                end else begin
                    ev_req.push = 1'b1;
                    if (found_reg) begin
                        valid_next[match_reg] = 1'b0;
                        ev_req.kind = KIND_END;
                    end else begin
                        ev_req.kind = KIND_NOTFOUND;
                    end
                end
                state_next = ST_FLUSH;
            end
            ST_FLUSH: begin
                ev_req.flush = 1'b1;
                if (ev_stat.ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
            evcnt_reg <= '0;
            found_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            evcnt_reg <= evcnt_next;
            found_reg <= found_next;
        end
        idx_reg <= idx_next;
        match_reg <= match_next;
        if (accept) begin
            cmd_reg <= s_tuser;
            id_reg <= s_tdata[7:0];
            reload_reg <= CW'(s_tdata[23:8]);
            rep_reg <= s_tdata[39:24];
        end
    end

    msst_ram #(
        .WIDTH(EW),
        .DEPTH(SLOTS),
        .AW   (IW)
    ) u_slot_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    msst_evq u_evq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (ev_req),
        .stat    (ev_stat),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    a_idle_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !ev_stat.pend_valid)
        else $error("event left pending after word completed");

    a_evcnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        evcnt_reg <= EVW'(MAX_RESULTS))
        else $error("event count beyond limit");

    a_write_state: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ST_SCAN || state_reg == ST_FIN))
        else $error("slot write outside scan or finish");

    a_push_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (ev_req.push && state_reg == ST_FIN) |-> ev_stat.ready)
        else $error("set or delete event blocked");

endmodule

// ----- rtl/msst_ram.sv -----
module msst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/msst_evq.sv -----
module msst_evq (
    input  logic               aclk,
    input  logic               aresetn,
    input  msst_pkg::ev_req_t  req,
    output msst_pkg::ev_stat_t stat,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata,  // event_timer_id
    output logic [1:0]         m_tuser,  // event_kind
    output logic               m_tlast   // last_event
);

    import msst_pkg::*;

    logic                pend_valid_reg, pend_valid_next;
    logic [1:0]          pend_kind_reg, pend_kind_next;
    logic [ID_WIDTH-1:0] pend_id_reg, pend_id_next;
    logic                out_valid_reg, out_valid_next;
    logic [1:0]          out_kind_reg, out_kind_next;
    logic [ID_WIDTH-1:0] out_id_reg, out_id_next;
    logic                out_last_reg, out_last_next;
    logic                out_free;
    logic                ready;

    assign out_free = !out_valid_reg || m_tready;
    assign ready = !pend_valid_reg || out_free;

    always_comb begin
        pend_valid_next = pend_valid_reg;
        pend_kind_next = pend_kind_reg;
        pend_id_next = pend_id_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_kind_next = out_kind_reg;
        out_id_next = out_id_reg;
        out_last_next = out_last_reg;
        if (ready && (req.push || req.flush)) begin
            if (pend_valid_reg) begin
                out_valid_next = 1'b1;
                out_kind_next = pend_kind_reg;
                out_id_next = pend_id_reg;
                out_last_next = req.flush;
            end
            if (req.push) begin
                pend_valid_next = 1'b1;
                pend_kind_next = req.kind;
                pend_id_next = req.id;
            end else begin
                pend_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg <= out_valid_next;
        end
        pend_kind_reg <= pend_kind_next;
        pend_id_reg <= pend_id_next;
        out_kind_reg <= out_kind_next;
        out_id_reg <= out_id_next;
        out_last_reg <= out_last_next;
    end

    assign stat.ready = ready;
    assign stat.pend_valid = pend_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_id_reg;
    assign m_tuser = out_kind_reg;
    assign m_tlast = out_last_reg;

endmodule

// ----- sim/multi_slot_software_timer_top_test.sv -----
`timescale 1ns / 100ps

module multi_slot_software_timer_top_test;
    import msst_pkg::*;

    localparam int SLOTS = 8;
    localparam int SETTLE_CYCLES = 2 * SLOTS + 4;
    localparam logic [1:0] CMD_NONE = 2'd3;

    typedef struct {
        logic [1:0] kind;
        logic [7:0] id;
        logic       last;
    } timer_event_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // timer_id, reload_ticks, repeat_count
    logic [1:0]  s_tuser;   // command
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // event_timer_id
    logic [1:0]  m_tuser;   // event_kind
    logic        m_tlast;   // last_event

    logic               tt_valid   [SLOTS];
    logic [7:0]         tt_id      [SLOTS];
    logic [15:0]        tt_reload  [SLOTS];
    logic [15:0]        tt_current [SLOTS];
    logic signed [15:0] tt_repeats [SLOTS];

    timer_event_t pending_events[$];
    timer_event_t want;
    int word_events;
    int fail_count;
    int burst_left;
    int hold_req;

    multi_slot_software_timer_top #(
        .SLOTS(SLOTS),
        .COUNT_WIDTH(16)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #(3_000_000);
        $display("== FAIL ==");
        $finish;
    end

    function automatic void post_event(logic [1:0] kind, logic [7:0] id);
        timer_event_t ev;
        if (word_events < MAX_RESULTS) begin
            ev.kind = kind;
            ev.id = id;
            ev.last = 1'b0;
            pending_events.push_back(ev);
            word_events++;
        end
    endfunction

    function automatic void step_timer_table(logic [1:0] cmd, logic [7:0] id,
                                             logic [15:0] reload,
                                             logic signed [15:0] reps);
        int slot;
        word_events = 0;
        slot = -1;
        for (int i = 0; i < SLOTS; i++)
            if (slot < 0 && tt_valid[i] && tt_id[i] == id)
                slot = i;
        case (cmd)
            CMD_SET: begin
                for (int i = 0; i < SLOTS; i++)
                    if (slot < 0 && !tt_valid[i])
                        slot = i;
                if (slot < 0) begin
                    post_event(KIND_FULL, id);
                end else begin
                    tt_valid[slot] = 1'b1;
                    tt_id[slot] = id;
                    tt_reload[slot] = reload;
                    tt_current[slot] = reload;
                    tt_repeats[slot] = reps;
                end
            end
            CMD_DELETE: begin
                if (slot < 0) begin
                    post_event(KIND_NOTFOUND, id);
                end else begin
                    tt_valid[slot] = 1'b0;
                    post_event(KIND_END, id);
                end
            end
            CMD_TICK: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (tt_valid[i]) begin
                        if (tt_current[i] != 16'd0) begin
                            tt_current[i] = tt_current[i] - 16'd1;
                        end else begin
                            tt_current[i] = tt_reload[i];
                            if (tt_repeats[i] > 0) begin
                                tt_repeats[i] = tt_repeats[i] - 16'sd1;
                                post_event(KIND_FIRE, tt_id[i]);
                            end else if (tt_repeats[i] == REP_FOREVER) begin
                                post_event(KIND_FIRE, tt_id[i]);
                            end else begin
                                tt_valid[i] = 1'b0;
                                post_event(KIND_END, tt_id[i]);
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        if (word_events > 0)
            pending_events[pending_events.size() - 1].last = 1'b1;
    endfunction

    task automatic send_word(input logic [1:0] cmd, input logic [7:0] id,
                             input logic [15:0] reload, input logic signed [15:0] reps);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {reps, reload, id};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        step_timer_table(cmd, id, reload, reps);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_events.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // receiver: long hold on request, otherwise changing stall patterns
    initial begin
        int mode;
        int mode_left;
        int hold_left;
        m_tready <= 1'b0;
        mode = 0;
        mode_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req = 0;
                m_tready <= 1'b0;
                while (hold_left > 0) begin
                    @(posedge aclk);
                    hold_left--;
                end
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_events.size() == 0) begin
                $error("unexpected word: event_kind %0d event_timer_id %0d",
                       m_tuser, m_tdata);
                fail_count++;
            end else begin
                want = pending_events.pop_front();
                if (m_tuser !== want.kind) begin
                    $error("event_kind: expected %0d, got %0d", want.kind, m_tuser);
                    fail_count++;
                end
                if (m_tdata !== want.id) begin
                    $error("event_timer_id: expected %0d, got %0d", want.id, m_tdata);
                    fail_count++;
                end
                if (m_tlast !== want.last) begin
                    $error("last_event: expected %0d, got %0d", want.last, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_directed();
        send_word(CMD_DELETE, 8'h55, 16'd0, 16'sd0);      // not found on empty table
        send_word(CMD_TICK, 8'h00, 16'd0, 16'sd0);        // nothing to report
        send_word(CMD_NONE, 8'hAA, 16'hFFFF, -16'sd1);    // ignored
        send_word(CMD_SET, 8'h00, 16'd0, 16'sd0);
        send_word(CMD_SET, 8'hFF, 16'hFFFF, 16'sd32767);
        send_word(CMD_SET, 8'h01, 16'd1, -16'sd1);
        send_word(CMD_SET, 8'h02, 16'd0, 16'sd2);
        send_word(CMD_SET, 8'h03, 16'd2, -16'sd5);        // below forever, ends at expiry
        repeat (4) send_word(CMD_TICK, 8'h00, 16'd0, 16'sd0);
        send_word(CMD_SET, 8'h02, 16'd3, 16'sd1);         // id 02 has ended by now; set again into a free slot
        for (int i = 0; i < 8; i++)
            send_word(CMD_SET, 8'(8'h80 + i), 16'd0, (i % 2 == 0) ? -16'sd1 : 16'sd3);
        send_word(CMD_TICK, 8'h00, 16'd0, 16'sd0);
        send_word(CMD_DELETE, 8'hFF, 16'd0, 16'sd0);
        send_word(CMD_DELETE, 8'h01, 16'd0, 16'sd0);
        send_word(CMD_TICK, 8'h00, 16'd0, 16'sd0);
        wait_idle();
    endtask

    task automatic test_random();
        int pick;
        logic [1:0] cmd;
        logic [7:0] id;
        logic [15:0] reload;
        logic signed [15:0] reps;
        for (int round = 0; round < 4; round++) begin
            for (int n = 0; n < 50; n++) begin
                pick = $urandom_range(0, 99);
                cmd = (pick < 35) ? CMD_SET : (pick < 50) ? CMD_DELETE :
                      (pick < 98) ? CMD_TICK : CMD_NONE;
                id = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                  : 8'h40 + 8'($urandom_range(0, 11));
                pick = $urandom_range(0, 9);
                reload = (pick < 7) ? 16'($urandom_range(0, 4)) :
                         (pick < 9) ? 16'($urandom_range(5, 20)) : 16'($urandom_range(0, 65535));
                pick = $urandom_range(0, 9);
                reps = (pick < 3) ? -16'sd1 :
                       (pick < 8) ? 16'($urandom_range(0, 4)) :
                       (pick < 9) ? 16'($urandom_range(0, 32767)) :
                       16'(-$urandom_range(2, 32768));
                send_word(cmd, id, reload, reps);
            end
            for (int i = 0; i < SLOTS; i++)
                if (tt_valid[i])
                    send_word(CMD_DELETE, tt_id[i], 16'($urandom_range(0, 65535)),
                              16'($urandom_range(0, 65535)));
        end
        wait_idle();
    endtask

    task automatic test_backpressure();
        hold_req = 400;
        for (int i = 0; i < SLOTS; i++)
            send_word(CMD_SET, 8'(8'h20 + i), 16'd0, -16'sd1);
        repeat (20) send_word(CMD_TICK, 8'h00, 16'd0, 16'sd0);
        for (int i = 0; i < SLOTS; i++)
            send_word(CMD_DELETE, 8'(8'h20 + i), 16'd0, 16'sd0);
        wait_idle();
    endtask

    initial begin
        for (int i = 0; i < SLOTS; i++)
            tt_valid[i] = 1'b0;
        fail_count = 0;
        burst_left = 0;
        hold_req = 0;
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= CMD_TICK;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random();
        test_backpressure();
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
